// ===== sv/vsa_pkg.sv =====
// Shared types and constants for the voice slot allocator.
// No dependencies; imported by vsa_slot_pick, voice_slot_allocator_with_ids and the bench.
package vsa_pkg;

    // busy_mask and slot_index cover this many slots
    localparam int MASK_SLOTS = 32;
    localparam int IDX_W      = 5;
    localparam int ID_W       = 32;
    localparam logic [ID_W-1:0] ID_RESET = 32'h0000_0001;

    typedef enum logic {
        CMD_ACQUIRE  = 1'b0,
        CMD_VALIDATE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } pick_t;

endpackage

// ===== sv/voice_slot_allocator_with_ids.sv =====
// Voice slot allocator with generational identifiers: top level.
// Depends on vsa_pkg and vsa_slot_pick.
//
//  channel | dir | tdata (lowest bit up)                          | tuser
//  s_      | in  | handle_slot, handle_id, busy_mask, group_active | cmd
//  m_      | out | slot_index, slot_id                            | ok
//
// One item per cycle sustained while m_tready stays high. An accepted item goes
// through the input register and one pass of pick/lookup logic into the result
// register, which drives m_tvalid.
// Slot state and the identifier counter update as an item leaves the input
// register, so the next item always sees the updated pool.
// Reset (aresetn low, synchronous) clears the valid bits of all slots,
// sets the counter to 1 and empties both registers.
// A stalled result register holds its item; the input register then fills
// and s_tready drops.
module voice_slot_allocator_with_ids #(
    parameter int POOL_SLOTS  = 32,
    parameter int GROUP_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] handle_slot, [63:32] handle_id, [95:64] busy_mask,
    // [97:96] group_active, [103:98] zero
    input  logic [103:0] s_tdata,
    // [0] cmd
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [4:0] slot_index, [36:5] slot_id, [39:37] zero
    output logic [39:0]  m_tdata,
    // [0] ok
    output logic         m_tuser
);
    import vsa_pkg::*;

    // only the slots the mask can name are ever used
    localparam int LIVE_SLOTS = (POOL_SLOTS < MASK_SLOTS) ? POOL_SLOTS : MASK_SLOTS;
    localparam int SLOT_W     = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;

    // input register
    logic             st_vld_reg,   st_vld_next;
    cmd_t             st_cmd_reg,   st_cmd_next;
    logic [31:0]      st_hslot_reg, st_hslot_next;
    logic [ID_W-1:0]  st_hid_reg,   st_hid_next;
    logic [31:0]      st_busy_reg,  st_busy_next;
    logic [1:0]       st_grp_reg,   st_grp_next;

    // result register
    logic             m_vld_reg,    m_vld_next;
    logic             m_ok_reg,     m_ok_next;
    logic [IDX_W-1:0] m_idx_reg,    m_idx_next;
    logic [ID_W-1:0]  m_id_reg,     m_id_next;

    // pool state
    logic [ID_W-1:0]       slot_ids_reg [LIVE_SLOTS];
    logic [LIVE_SLOTS-1:0] slot_vld_reg, slot_vld_next;
    logic [ID_W-1:0]       id_counter_reg, id_counter_next;

    logic              s_acc;
    logic              advance;
    pick_t             pick;
    logic              acq_hit;
    logic [SLOT_W-1:0] widx;
    logic [SLOT_W-1:0] ridx;
    logic              in_range;
    logic              val_hit;

    vsa_slot_pick #(
        .LIVE_SLOTS  (LIVE_SLOTS),
        .GROUP_SLOTS (GROUP_SLOTS)
    ) u_pick (
        .busy_mask    (st_busy_reg),
        .group_active (st_grp_reg),
        .pick         (pick)
    );

    // advance the held item whenever the result register is free or draining
    assign advance  = st_vld_reg && (!m_vld_reg || m_tready);
    assign s_tready = !st_vld_reg || advance;
    assign s_acc    = s_tvalid && s_tready;

    // acquire path: lowest free slot gets the counter
    assign acq_hit = (st_cmd_reg == CMD_ACQUIRE) && pick.found;
    assign widx    = pick.idx[SLOT_W-1:0];

    // validate path: range check, stamped check, identifier compare
    assign in_range = st_hslot_reg < 32'(LIVE_SLOTS);
    assign ridx     = st_hslot_reg[SLOT_W-1:0];
    assign val_hit  = (st_cmd_reg == CMD_VALIDATE) && in_range && slot_vld_reg[ridx]
                      && (slot_ids_reg[ridx] == st_hid_reg);

    always_comb begin
        st_vld_next   = st_vld_reg;
        st_cmd_next   = st_cmd_reg;
        st_hslot_next = st_hslot_reg;
        st_hid_next   = st_hid_reg;
        st_busy_next  = st_busy_reg;
        st_grp_next   = st_grp_reg;
        if (s_acc) begin
            st_vld_next   = 1'b1;
            st_cmd_next   = cmd_t'(s_tuser);
            st_hslot_next = s_tdata[31:0];
            st_hid_next   = s_tdata[63:32];
            st_busy_next  = s_tdata[95:64];
            st_grp_next   = s_tdata[97:96];
        end else if (advance) begin
            st_vld_next = 1'b0;
        end
    end

    always_comb begin
        m_vld_next      = m_vld_reg;
        m_ok_next       = m_ok_reg;
        m_idx_next      = m_idx_reg;
        m_id_next       = m_id_reg;
        slot_vld_next   = slot_vld_reg;
        id_counter_next = id_counter_reg;
        if (advance) begin
            m_vld_next = 1'b1;
            // failure result is all zeros
            m_ok_next  = 1'b0;
            m_idx_next = '0;
            m_id_next  = '0;
            if (acq_hit) begin
                m_ok_next             = 1'b1;
                m_idx_next            = pick.idx;
                m_id_next             = id_counter_reg;
                slot_vld_next[widx]   = 1'b1;
                id_counter_next       = id_counter_reg + ID_W'(1);
            end else if (val_hit) begin
                m_ok_next  = 1'b1;
                m_idx_next = IDX_W'(ridx);
                m_id_next  = slot_ids_reg[ridx];
            end
        end else if (m_tready) begin
            m_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_vld_reg     <= 1'b0;
            m_vld_reg      <= 1'b0;
            slot_vld_reg   <= '0;
            id_counter_reg <= ID_RESET;
        end else begin
            st_vld_reg     <= st_vld_next;
            m_vld_reg      <= m_vld_next;
            slot_vld_reg   <= slot_vld_next;
            id_counter_reg <= id_counter_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        st_cmd_reg   <= st_cmd_next;
        st_hslot_reg <= st_hslot_next;
        st_hid_reg   <= st_hid_next;
        st_busy_reg  <= st_busy_next;
        st_grp_reg   <= st_grp_next;
        m_ok_reg     <= m_ok_next;
        m_idx_reg    <= m_idx_next;
        m_id_reg     <= m_id_next;
    end

    // stamp the acquired slot; unstamped entries are masked by their valid bit
    always_ff @(posedge aclk) begin
        for (int i = 0; i < LIVE_SLOTS; i++) begin
            if (advance && acq_hit && (widx == SLOT_W'(i))) begin
                slot_ids_reg[i] <= id_counter_reg;
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {3'b000, m_id_reg, m_idx_reg};

    // counter only ever steps by one
    a_counter_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (id_counter_reg != $past(id_counter_reg))
        |-> (id_counter_reg == $past(id_counter_reg) + ID_W'(1)))
        else $error("identifier counter jumped");

    // input side stalls only when both registers are full and the output waits
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (st_vld_reg && m_vld_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // an acquired slot is marked stamped from the next cycle on
    a_stamp_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && acq_hit) |=> slot_vld_reg[$past(widx)])
        else $error("acquired slot not marked valid");

    // a failed result carries no slot or identifier
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && !m_ok_reg) |-> (m_idx_reg == '0 && m_id_reg == '0))
        else $error("failure result not zeroed");

endmodule

// ===== sv/vsa_slot_pick.sv =====
// Lowest free slot search over the busy mask and the active groups.
// Depends on vsa_pkg for pick_t and mask widths.
module vsa_slot_pick #(
    parameter int LIVE_SLOTS  = 32,
    parameter int GROUP_SLOTS = 16
) (
    input  logic [31:0]   busy_mask,
    input  logic [1:0]    group_active,
    output vsa_pkg::pick_t pick
);
    import vsa_pkg::*;

    logic [MASK_SLOTS-1:0] elig;
    logic [MASK_SLOTS-1:0] lowest;
    logic [IDX_W-1:0]      enc;

    always_comb begin
        for (int i = 0; i < MASK_SLOTS; i++) begin
            elig[i] = (i < LIVE_SLOTS) && !busy_mask[i]
                      && ((i < GROUP_SLOTS) ? group_active[0] : group_active[1]);
        end
        // isolate the lowest set bit, then encode the one-hot result
        lowest = elig & (~elig + MASK_SLOTS'(1));
        enc    = '0;
        for (int i = 0; i < MASK_SLOTS; i++) begin
            if (lowest[i]) begin
                enc = enc | IDX_W'(i);
            end
        end
        pick.found = |elig;
        pick.idx   = enc;
    end

endmodule

// ===== tb/sv/voice_slot_allocator_with_ids_tb.sv =====
// Self-checking bench for voice_slot_allocator_with_ids: a directed table, then random items,
// every result checked against a slot pool predictor kept inside the bench.
// Depends on vsa_pkg and the voice_slot_allocator_with_ids RTL.
module voice_slot_allocator_with_ids_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vsa_pkg::*;

    localparam int POOL_SLOTS      = 32;
    localparam int GROUP_SLOTS     = 16;
    // busy_mask and slot_index only reach the first MASK_SLOTS slots
    localparam int LIVE_SLOTS      = (POOL_SLOTS < MASK_SLOTS) ? POOL_SLOTS : MASK_SLOTS;
    localparam int ITEM_COUNT      = 1250;
    localparam int CALM_ITEMS      = 150;
    localparam int HOLD_OFF_AT     = 400;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int HANDLE_KEEP     = 48;
    localparam int OPENING_COUNT   = 21;
    localparam logic [ID_W-1:0] ID_NONE = 32'hFFFF_FFFF;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  id;
    } slot_result_t;

    typedef struct packed {
        logic [31:0]     slot;
        logic [ID_W-1:0] id;
    } handle_t;

    typedef struct packed {
        cmd_t         cmd;
        logic [31:0]  hslot;
        logic [31:0]  hid;
        logic [31:0]  busy;
        logic [1:0]   groups;
        logic         fixed;   // use the typed-in result instead of the predictor
        slot_result_t want;
    } stim_row_t;

    localparam slot_result_t NO_SLOT = '0;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // [31:0] handle_slot, [63:32] handle_id, [95:64] busy_mask, [97:96] group_active, [103:98] 0
    logic [103:0] s_tdata;
    // [0] cmd
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // [4:0] slot_index, [36:5] slot_id, [39:37] 0
    logic [39:0]  m_tdata;
    // [0] ok
    logic         m_tuser;

    // predictor state: issued identifier per slot, stamped flags, next identifier
    logic [ID_W-1:0] pool_ids [POOL_SLOTS];
    logic            pool_stamped [POOL_SLOTS];
    logic [ID_W-1:0] next_id;

    slot_result_t awaited_results [$];
    handle_t      issued_handles [$];

    // what the item now on the input carries as a typed-in result, if any
    logic         item_fixed;
    slot_result_t item_want;

    int error_count;
    bit calm_tail;
    bit hold_off_request;
    bit hold_off_active;

    // Opening table: extremes of the handle fields, both commands, empty pool, inactive groups,
    // out-of-range handles, never-stamped slots, stale handles and slot reuse.
    stim_row_t opening_rows [OPENING_COUNT] = '{
        // never-stamped slot, handle carries the all-ones identifier
        '{CMD_VALIDATE, 32'd0, ID_NONE, 32'd0, 2'd3, 1'b1, NO_SLOT},
        // no group active
        '{CMD_ACQUIRE, ID_NONE, ID_NONE, 32'd0, 2'd0, 1'b1, NO_SLOT},
        // every slot busy
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'hFFFF_FFFF, 2'd3, 1'b1, NO_SLOT},
        // first acquire after reset takes slot 0 with identifier 1
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'd0, 2'd3, 1'b1, '{1'b1, 5'd0, 32'd1}},
        '{CMD_VALIDATE, 32'd0, 32'd1, 32'd0, 2'd3, 1'b1, '{1'b1, 5'd0, 32'd1}},
        '{CMD_VALIDATE, 32'd0, 32'd2, 32'd0, 2'd3, 1'b1, NO_SLOT},
        // handle slot just past the pool, and at the top of its range
        '{CMD_VALIDATE, 32'd32, 32'd1, 32'd0, 2'd3, 1'b1, NO_SLOT},
        '{CMD_VALIDATE, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 2'd3, 1'b1, NO_SLOT},
        // first half full and second half inactive
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'h0000_FFFF, 2'd1, 1'b1, NO_SLOT},
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'h0000_FFFF, 2'd3, 1'b1, '{1'b1, 5'd16, 32'd2}},
        // only the top slot free
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'h7FFF_FFFF, 2'd2, 1'b1, '{1'b1, 5'd31, 32'd3}},
        '{CMD_VALIDATE, 32'd31, 32'd3, 32'd0, 2'd0, 1'b1, '{1'b1, 5'd31, 32'd3}},
        '{CMD_VALIDATE, 32'd31, 32'd0, 32'd0, 2'd3, 1'b1, NO_SLOT},
        // slot 0 reissued, the old handle goes stale
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'hFFFF_FFFE, 2'd1, 1'b1, '{1'b1, 5'd0, 32'd4}},
        '{CMD_VALIDATE, 32'd0, 32'd1, 32'd0, 2'd3, 1'b1, NO_SLOT},
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'hAAAA_AAAA, 2'd3, 1'b0, NO_SLOT},
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'h5555_5555, 2'd2, 1'b0, NO_SLOT},
        '{CMD_VALIDATE, 32'd17, 32'd6, 32'd0, 2'd3, 1'b0, NO_SLOT},
        '{CMD_ACQUIRE, 32'd0, 32'd0, 32'd0, 2'd2, 1'b0, NO_SLOT},
        '{CMD_VALIDATE, 32'd16, 32'd2, 32'd0, 2'd3, 1'b0, NO_SLOT},
        '{CMD_VALIDATE, 32'd1, ID_NONE, 32'd0, 2'd3, 1'b1, NO_SLOT}
    };

    voice_slot_allocator_with_ids #(
        .POOL_SLOTS  (POOL_SLOTS),
        .GROUP_SLOTS (GROUP_SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Advance the pool by one item and return the result it should produce.
    // Acquire stamps the lowest free slot in an active half; validate leaves the pool alone.
    function automatic slot_result_t pool_step(input cmd_t cmd, input logic [31:0] hslot,
                                               input logic [31:0] hid, input logic [31:0] busy,
                                               input logic [1:0] groups);
        slot_result_t res;
        int           half;
        res = NO_SLOT;
        if (cmd == CMD_ACQUIRE) begin
            for (int i = 0; i < LIVE_SLOTS; i++) begin
                half = (i < GROUP_SLOTS) ? 0 : 1;
                if (groups[half] && !busy[i]) begin
                    pool_ids[i]     = next_id;
                    pool_stamped[i] = 1'b1;
                    res             = '{1'b1, IDX_W'(i), next_id};
                    issued_handles.push_back('{32'(i), next_id});
                    if (issued_handles.size() > HANDLE_KEEP) begin
                        void'(issued_handles.pop_front());
                    end
                    next_id = next_id + 1'b1;
                    return res;
                end
            end
        end else if (hslot < LIVE_SLOTS) begin
            if (pool_stamped[hslot] && pool_ids[hslot] == hid) begin
                res = '{1'b1, hslot[IDX_W-1:0], hid};
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Offer one item from the falling edge and hold it until the block takes it.
    // Drop valid for a burst first when the sender is in a gappy stretch.
    task automatic offer_item(input cmd_t cmd, input logic [31:0] hslot, input logic [31:0] hid,
                              input logic [31:0] busy, input logic [1:0] groups,
                              input logic fixed, input slot_result_t want, input bit gappy);
        @(negedge aclk);
        if (gappy && !calm_tail && !hold_off_active && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tuser    <= cmd;
        s_tdata    <= {6'b0, groups, busy, hid, hslot};
        item_fixed = fixed;
        item_want  = want;
        s_tvalid   <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Score at the rising edge, on values from before the edge. Check the leaving
    // result before queueing the new item, so an item never meets its own result.
    always @(posedge aclk) begin : slot_scoreboard
        slot_result_t got;
        slot_result_t want;
        slot_result_t model;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[4:0], m_tdata[36:5]};
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, {31'd0, got.ok});
                end else begin
                    want = awaited_results.pop_front();
                    if (got.ok !== want.ok) begin
                        report_mismatch("ok", {31'd0, want.ok}, {31'd0, got.ok});
                    end
                    if (got.idx !== want.idx) begin
                        report_mismatch("slot_index", 32'(want.idx), 32'(got.idx));
                    end
                    if (got.id !== want.id) begin
                        report_mismatch("slot_id", want.id, got.id);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                model = pool_step(cmd_t'(s_tuser), s_tdata[31:0], s_tdata[63:32],
                                  s_tdata[95:64], s_tdata[97:96]);
                awaited_results.push_back(item_fixed ? item_want : model);
            end
        end
    end

    // End the run if no item moves on either side for too long.
    always @(posedge aclk) begin : stall_watchdog
        int idle_cycles;
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, calm stretches, one long hold-off on request,
    // and always ready once the tail of the run starts.
    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_off_active  = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_active = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (!calm_tail && $urandom_range(0, 15) == 0) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        stim_row_t   row;
        handle_t     h;
        cmd_t        cmd;
        logic [31:0] hslot;
        logic [31:0] hid;
        logic [31:0] busy;
        logic [1:0]  groups;
        int          kind;
        int          lowk;
        bit          gappy;

        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        item_fixed       = 1'b0;
        item_want        = NO_SLOT;
        error_count      = 0;
        calm_tail        = 1'b0;
        hold_off_request = 1'b0;
        hold_off_active  = 1'b0;
        gappy            = 1'b1;
        for (int i = 0; i < POOL_SLOTS; i++) begin
            pool_ids[i]     = ID_NONE;
            pool_stamped[i] = 1'b0;
        end
        next_id = ID_RESET;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < OPENING_COUNT; n++) begin
            row = opening_rows[n];
            offer_item(row.cmd, row.hslot, row.hid, row.busy, row.groups, row.fixed, row.want,
                       1'b1);
        end

        for (int n = OPENING_COUNT; n < ITEM_COUNT; n++) begin
            calm_tail = (n >= ITEM_COUNT - CALM_ITEMS);
            if (n == HOLD_OFF_AT) begin
                hold_off_request = 1'b1;
            end
            if (n % 64 == 0) begin
                gappy = ($urandom_range(0, 2) != 0);
            end

            // Fields that the command ignores still carry random values.
            hslot = $urandom;
            hid   = $urandom;
            busy  = $urandom;
            kind  = $urandom_range(0, 9);
            case ($urandom_range(0, 9))
                0:       groups = 2'd0;
                1, 2:    groups = 2'd1;
                3, 4:    groups = 2'd2;
                default: groups = 2'd3;
            endcase

            if ($urandom_range(0, 1) == 0) begin
                // acquire: often masks with a busy run at the bottom and sparse busy bits above
                cmd = CMD_ACQUIRE;
                case (kind)
                    0, 1, 2, 3: begin
                        lowk = $urandom_range(0, 31);
                        busy = ($urandom & $urandom) |
                               ((lowk == 0) ? 32'd0 : (32'hFFFF_FFFF >> (32 - lowk)));
                    end
                    4, 5, 6: busy = $urandom;
                    7:       busy = 32'hFFFF_FFFF;
                    8:       busy = $urandom | $urandom;
                    default: busy = 32'd0;
                endcase
            end else begin
                // validate: mostly handles that were issued, some stale or corrupted
                cmd = CMD_VALIDATE;
                if (issued_handles.size() == 0) begin
                    kind = 9;
                end else begin
                    h = issued_handles[$urandom_range(0, issued_handles.size() - 1)];
                end
                case (kind)
                    0, 1, 2, 3, 4, 5: begin
                        hslot = h.slot;
                        hid   = h.id;
                    end
                    6: begin
                        hslot = h.slot;
                        hid   = h.id ^ (32'd1 << $urandom_range(0, 31));
                    end
                    7: begin
                        hslot = $urandom_range(0, LIVE_SLOTS - 1);
                        hid   = h.id;
                    end
                    8: begin
                        hslot = ($urandom_range(0, 3) == 0) ? 32'(LIVE_SLOTS) : $urandom;
                        if (hslot < LIVE_SLOTS) begin
                            hslot = hslot + LIVE_SLOTS;
                        end
                    end
                    default: hslot = $urandom_range(0, LIVE_SLOTS - 1);
                endcase
            end
            offer_item(cmd, hslot, hid, busy, groups, 1'b0, NO_SLOT, gappy);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain: wait for every awaited result, then watch on for strays.
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
